/* rtl/core/etp_pkg.sv */
// Shared types and constants for the execution time profiler.
package etp_pkg;

	// Number of profiled slots and the width of a slot index.
	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W    = 4;
	localparam int TIMER_W   = 16;
	localparam int STAT_W    = 32;
	localparam int MASK_W    = 16;

	// Minimum duration reported when no call has been recorded.
	localparam logic [STAT_W-1:0] NO_CALL_MIN = 32'hFFFF_FFFF;

	// Request codes.
	typedef enum logic [1:0] {
		REQ_ENTER = 2'd0,
		REQ_EXIT  = 2'd1,
		REQ_READ  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_type_t;

	// One request as held in the input stage.
	typedef struct packed {
		req_type_t          req_type;
		logic [SLOT_W-1:0]  slot_id;
		logic [TIMER_W-1:0] timer_value;
	} req_t;

	// One result as held in the output register.
	typedef struct packed {
		logic               accepted;
		logic [STAT_W-1:0]  calls;
		logic [STAT_W-1:0]  cycles_total;
		logic [STAT_W-1:0]  cycles_min;
		logic [TIMER_W-1:0] cycles_max;
	} result_t;

endpackage

/* rtl/core/execution_time_profiler.sv */
// A request accepted into the input register shows its result from the result register.
// Throughput: one request per cycle unless the result stalls; the slot table is
// read and written between the input register and the result register.
// A stalled result holds the input register, which still refills once behind it.
// Reset (arst_n low) clears the mask and every slot: stamps, counts and totals
// to zero, minimum to all ones, maximum to zero. No clearing pass is needed.
module execution_time_profiler
	import etp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write channel.
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [MASK_W-1:0]  active_mask,
	// Request channel.
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [SLOT_W-1:0]  slot_id,
	input  logic [TIMER_W-1:0] timer_value,
	// Result channel.
	output logic               out_valid,
	input  logic               out_ready,
	output logic               accepted,
	output logic [STAT_W-1:0]  calls,
	output logic [STAT_W-1:0]  cycles_total,
	output logic [STAT_W-1:0]  cycles_min,
	output logic [TIMER_W-1:0] cycles_max
);

	logic [MASK_W-1:0] mask_q;
	req_t              req_s1;
	logic              valid_s1;
	result_t           res_s2;
	logic              valid_s2;
	result_t           res_comb;
	logic              advance;

	// Mask register; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_valid) begin
			mask_q <= active_mask;
		end
	end

	// The input stage moves on whenever the result register is free or draining.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= '{req_type: req_type_t'(req_type), slot_id: slot_id,
				timer_value: timer_value};
		end
	end

	// Slot statistics and their update.
	etp_slot_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.mask   (mask_q),
		.req    (req_s1),
		.commit (advance),
		.result (res_comb)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	// Result ports.
	assign out_valid    = valid_s2;
	assign accepted     = res_s2.accepted;
	assign calls        = res_s2.calls;
	assign cycles_total = res_s2.cycles_total;
	assign cycles_min   = res_s2.cycles_min;
	assign cycles_max   = res_s2.cycles_max;

endmodule

/* rtl/core/etp_slot_table.sv */
// Per-slot statistics storage and the update logic for one request.
module etp_slot_table
	import etp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [MASK_W-1:0] mask,
	input  req_t              req,
	input  logic              commit,
	output result_t           result
);

	logic [TIMER_W-1:0] stamp_q [NUM_SLOTS];
	logic [STAT_W-1:0]  tally_q [NUM_SLOTS];
	logic [STAT_W-1:0]  sum_q   [NUM_SLOTS];
	logic [STAT_W-1:0]  low_q   [NUM_SLOTS];
	logic [TIMER_W-1:0] high_q  [NUM_SLOTS];

	logic               slot_ok;
	logic [TIMER_W-1:0] dur;
	logic [TIMER_W-1:0] stamp_nxt;
	logic [STAT_W-1:0]  tally_nxt;
	logic [STAT_W-1:0]  sum_nxt;
	logic [STAT_W-1:0]  low_nxt;
	logic [TIMER_W-1:0] high_nxt;

	// The slot takes part only when it exists and its mask bit is set.
	assign slot_ok = (32'(req.slot_id) < NUM_SLOTS) && mask[req.slot_id];

	// Duration modulo the timer width, so a timer wrap is measured correctly.
	assign dur = req.timer_value - stamp_q[req.slot_id];

	// New slot contents for the request at hand.
	always_comb begin
		stamp_nxt = stamp_q[req.slot_id];
		tally_nxt = tally_q[req.slot_id];
		sum_nxt   = sum_q[req.slot_id];
		low_nxt   = low_q[req.slot_id];
		high_nxt  = high_q[req.slot_id];
		case (req.req_type)
			REQ_ENTER: begin
				stamp_nxt = req.timer_value;
			end
			REQ_EXIT: begin
				tally_nxt = tally_q[req.slot_id] + 32'd1;
				sum_nxt   = sum_q[req.slot_id] + {16'd0, dur};
				if ({16'd0, dur} < low_q[req.slot_id]) begin
					low_nxt = {16'd0, dur};
				end
				if (dur > high_q[req.slot_id]) begin
					high_nxt = dur;
				end
			end
			REQ_CLEAR: begin
				tally_nxt = '0;
				sum_nxt   = '0;
				low_nxt   = NO_CALL_MIN;
				high_nxt  = '0;
			end
			default: begin
			end
		endcase
	end

	// Statistics after the request; a rejected request reports all zero.
	always_comb begin
		result = '0;
		if (slot_ok) begin
			result.accepted     = 1'b1;
			result.calls        = tally_nxt;
			result.cycles_total = sum_nxt;
			result.cycles_min   = low_nxt;
			result.cycles_max   = high_nxt;
		end
	end

	// Write back the slot when the request moves on to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				stamp_q[i] <= '0;
				tally_q[i] <= '0;
				sum_q[i]   <= '0;
				low_q[i]   <= NO_CALL_MIN;
				high_q[i]  <= '0;
			end
		end else if (commit && slot_ok) begin
			stamp_q[req.slot_id] <= stamp_nxt;
			tally_q[req.slot_id] <= tally_nxt;
			sum_q[req.slot_id]   <= sum_nxt;
			low_q[req.slot_id]   <= low_nxt;
			high_q[req.slot_id]  <= high_nxt;
		end
	end

endmodule

/* rtl/core/etp_checker.sv */
// Port-level checks for the execution time profiler, bound to the top level.
module etp_checker
	import etp_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               accepted,
	input logic [STAT_W-1:0]  calls,
	input logic [STAT_W-1:0]  cycles_total,
	input logic [STAT_W-1:0]  cycles_min,
	input logic [TIMER_W-1:0] cycles_max
);

	// A stalled result keeps its valid and its fields.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(accepted) && $stable(calls)
			&& $stable(cycles_total) && $stable(cycles_min) && $stable(cycles_max))
		else $error("result changed while stalled");

	// A rejected request reports all statistics as zero.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> calls == '0 && cycles_total == '0
			&& cycles_min == '0 && cycles_max == '0)
		else $error("rejected request reported nonzero statistics");

	// Once a call is recorded, the minimum never exceeds the maximum.
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted && cycles_min != NO_CALL_MIN
			|-> cycles_min <= {16'd0, cycles_max})
		else $error("minimum duration above maximum duration");

	// With no call recorded, the maximum is still zero.
	a_no_call_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted && cycles_min == NO_CALL_MIN |-> cycles_max == '0)
		else $error("maximum set while no call is recorded");

endmodule

bind execution_time_profiler etp_checker u_etp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.accepted     (accepted),
	.calls        (calls),
	.cycles_total (cycles_total),
	.cycles_min   (cycles_min),
	.cycles_max   (cycles_max)
);
